// ===== hdl/radix_prefix_number_parser_defines.svh =====
// Assertion macros for the radix prefix number parser.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RADIX_PREFIX_NUMBER_PARSER_DEFINES_SVH
`define RADIX_PREFIX_NUMBER_PARSER_DEFINES_SVH

// same-cycle implication
`define RPPN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPPN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rppn_pkg.sv =====
// Shared types and constants for the radix prefix number parser.
// No dependencies.
package rppn_pkg;

  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int OUT_W   = 32;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;
  localparam logic [1:0] RADIX_OCT = 2'd3;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_SAT    = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_LO_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_UP_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CHAR_LO_O  = 8'h6f;
  localparam logic [CHAR_W-1:0] CHAR_UP_O  = 8'h4f;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  localparam logic [DIGIT_W-1:0] LIMIT_DEC = 4'd10;
  localparam logic [DIGIT_W-1:0] LIMIT_BIN = 4'd2;
  localparam logic [DIGIT_W-1:0] LIMIT_OCT = 4'd8;

  typedef struct packed {
    logic               is_term;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               is_prefix;
    logic [1:0]         prefix_radix;
  } char_class_t;

endpackage

// ===== hdl/rppn_char_decode.sv =====
// Character classifier: terminator, digit value, radix prefix letter.
// Depends on rppn_pkg.
module rppn_char_decode
  import rppn_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output char_class_t       cls
);

  always_comb begin
    cls              = '0;
    cls.is_term      = (char_code == CHAR_NUL);
    priority if (char_code >= CHAR_0 && char_code <= CHAR_9) begin
      cls.is_digit = 1'b1;
      cls.digit    = DIGIT_W'(char_code - CHAR_0);
    end else if (char_code >= CHAR_LO_A && char_code <= CHAR_LO_F) begin
      cls.is_digit = 1'b1;
      cls.digit    = DIGIT_W'(char_code - CHAR_LO_A) + DIGIT_TEN;
    end else if (char_code >= CHAR_UP_A && char_code <= CHAR_UP_F) begin
      cls.is_digit = 1'b1;
      cls.digit    = DIGIT_W'(char_code - CHAR_UP_A) + DIGIT_TEN;
    end else begin
      cls.is_digit = 1'b0;
    end
    priority if (char_code == CHAR_LO_X || char_code == CHAR_UP_X) begin
      cls.is_prefix    = 1'b1;
      cls.prefix_radix = RADIX_HEX;
    end else if (char_code == CHAR_LO_B || char_code == CHAR_UP_B) begin
      cls.is_prefix    = 1'b1;
      cls.prefix_radix = RADIX_BIN;
    end else if (char_code == CHAR_LO_O || char_code == CHAR_UP_O) begin
      cls.is_prefix    = 1'b1;
      cls.prefix_radix = RADIX_OCT;
    end else begin
      cls.is_prefix    = 1'b0;
    end
  end

endmodule

// ===== hdl/rppn_core.sv =====
// Parser state and per-character update (shift-add scale by radix).
// Depends on rppn_pkg.
module rppn_core
  import rppn_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   last,
  input  char_class_t            cls,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic                   res_valid
);

  logic [VALUE_WIDTH-1:0] accum, accum_next, scaled;
  logic [1:0]             radix, radix_next;
  logic [1:0]             pos, pos_next;
  logic                   stopped, stopped_next;
  logic                   saw_digit, saw_digit_next;
  logic                   err, err_next;
  logic                   digit_ok, in_range;

  always_comb begin
    unique case (radix)
      RADIX_DEC: begin
        scaled   = (accum << 3) + (accum << 1);
        in_range = (cls.digit < LIMIT_DEC);
      end
      RADIX_HEX: begin
        scaled   = accum << 4;
        in_range = 1'b1;
      end
      RADIX_BIN: begin
        scaled   = accum << 1;
        in_range = (cls.digit < LIMIT_BIN);
      end
      RADIX_OCT: begin
        scaled   = accum << 3;
        in_range = (cls.digit < LIMIT_OCT);
      end
      default: begin
        scaled   = accum;
        in_range = 1'b0;
      end
    endcase
    digit_ok = cls.is_digit && in_range;
  end

  always_comb begin
    accum_next     = accum;
    radix_next     = radix;
    pos_next       = (pos == POS_SAT) ? pos : pos + 2'd1;
    stopped_next   = stopped;
    saw_digit_next = saw_digit;
    err_next       = err;
    if (!stopped) begin
      priority if (cls.is_term) begin
        stopped_next = 1'b1;
      end else if (pos == POS_SECOND && cls.is_prefix && saw_digit &&
                   accum == '0 && radix == RADIX_DEC) begin
        radix_next     = cls.prefix_radix;
        saw_digit_next = 1'b0;
        accum_next     = '0;
      end else if (!digit_ok) begin
        stopped_next = 1'b1;
        err_next     = 1'b1;
      end else begin
        accum_next     = scaled + {{(VALUE_WIDTH-DIGIT_W){1'b0}}, cls.digit};
        saw_digit_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      accum     <= '0;
      radix     <= RADIX_DEC;
      pos       <= POS_FIRST;
      stopped   <= 1'b0;
      saw_digit <= 1'b0;
      err       <= 1'b0;
    end else if (step) begin
      accum     <= accum_next;
      radix     <= radix_next;
      pos       <= pos_next;
      stopped   <= stopped_next;
      saw_digit <= saw_digit_next;
      err       <= err_next;
    end
  end

  assign res_value = accum_next;
  assign res_valid = saw_digit_next && !err_next;

endmodule

// ===== hdl/radix_prefix_number_parser.sv =====
// Top level of the radix prefix number parser: input register, parser core,
// result register. Depends on rppn_pkg, rppn_char_decode, rppn_core.
//
// Usage:
//   Input stream: one ASCII character per request on s_axis_tdata, with
//   s_axis_tlast on the final character of a string. A leading 0x/0b/0o
//   (any case) selects base 16/2/8, else base 10. A NUL ends the string
//   early; a bad digit stops parsing and marks the number invalid.
//   Output stream: one request per string, issued for the tlast character:
//   m_axis_tdata carries the low 32 bits of the value, m_axis_tuser the
//   valid-number flag.
//   The tlast character passes the input register, then the result register,
//   where m_axis_tvalid rises; a full result register can hold it back.
//   Throughput: one character per cycle while no tlast character waits for
//   a full result register.
//   A receiver stall holds the result register; characters that end no
//   string keep flowing, and input stops only when a tlast character waits
//   for a full result register.
//   Reset (rst, synchronous) empties both registers and returns the parser
//   to base ten with no digits seen.
`include "radix_prefix_number_parser_defines.svh"

module radix_prefix_number_parser
  import rppn_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
  input  logic              s_axis_tlast,   // last_char
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [31:0] value
  output logic [0:0]        m_axis_tuser    // [0] valid_number
);

  localparam int WIDE_W = VALUE_WIDTH + OUT_W;

  logic              in_vld;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  logic              consume;
  char_class_t       cls;
  logic [VALUE_WIDTH-1:0] res_value;
  logic              res_valid;
  logic [WIDE_W-1:0] res_wide;

  assign consume       = in_vld && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  rppn_char_decode u_decode (
    .char_code (in_char),
    .cls       (cls)
  );

  rppn_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (consume),
    .last      (in_last),
    .cls       (cls),
    .res_value (res_value),
    .res_valid (res_valid)
  );

  assign res_wide = {{OUT_W{1'b0}}, res_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (consume && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      m_axis_tdata    <= res_wide[OUT_W-1:0];
      m_axis_tuser[0] <= res_valid;
    end
  end

  `RPPN_ASSERT_NXT(a_last_emits, consume && in_last, m_axis_tvalid, "string end lost")
  `RPPN_ASSERT_IMP(a_stall_cause, !s_axis_tready,
    in_vld && in_last && m_axis_tvalid && !m_axis_tready, "input stalled without cause")
  `RPPN_ASSERT_IMP(a_rise_cause, $rose(m_axis_tvalid),
    $past(consume && in_last), "result without string end")

endmodule
